### sv/bsi_pkg.sv
// Package with shared constants for the breakpoint size interpolator.
`timescale 1ns / 1ps
`default_nettype none
package bsi_pkg;
    localparam int         MAX_ITEMS     = 8;
    localparam logic [1:0] MODE_DISCRETE = 2'd0;
    localparam logic [1:0] MODE_LINEAR   = 2'd1;
    localparam logic [1:0] MODE_VALUE    = 2'd2;
    localparam logic [1:0] MODE_CONST    = 2'd3;
    localparam logic [1:0] CFG_MODE      = 2'd0;
    localparam logic [1:0] CFG_SIZE_TYPE = 2'd1;
    localparam logic [1:0] CFG_COUNT     = 2'd2;
    localparam logic       REQ_WRITE     = 1'b0;
    localparam logic       REQ_CLASSIFY  = 1'b1;
endpackage
`default_nettype wire

### sv/bsi_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bsi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### sv/breakpoint_size_interpolator_core.sv
// Top level of the breakpoint size interpolator.
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_stall    req_type, entry_index, entry_value,
//                                           entry_size, class_value
// out       output     out_valid/out_stall  out_size, status
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A write, a value-is-size request or an empty table gives its result in the cycle after the
// transfer. A table scan reads each entry from the RAM, then compares it. Linear mode then
// forms the products, runs a restoring division, takes the square root of diameter sizes
// and loads the result. Reset clears control state and the configuration registers;
// the table is undefined until written. A result waits in the output register; the next
// item is taken only once it is gone.
`timescale 1ns / 1ps
`default_nettype none
module breakpoint_size_interpolator_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        req_type,
    input  wire logic [2:0]  entry_index,
    input  wire logic signed [31:0] entry_value,
    input  wire logic [15:0] entry_size,
    input  wire logic signed [31:0] class_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      out_size,
    output logic             status,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [3:0]  cfg_data
);
    localparam int AW = $clog2(bsi_pkg::MAX_ITEMS);
    localparam int CW = $clog2(bsi_pkg::MAX_ITEMS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_SQRT = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]  state_reg;
    logic [1:0]  mode_reg;
    logic        size_type_reg;
    logic [3:0]  count_cfg_reg;
    logic [CW-1:0] count_eff;
    logic [CW-1:0] idx_reg;     // entry whose read is in flight
    logic        rd_pend_reg;   // read data valid next cycle
    logic signed [31:0] v_reg, lo_reg;
    logic [15:0] ls_reg;
    logic        have_lo_reg;
    logic [63:0] num_reg, quo_reg;
    logic [33:0] den_reg;
    logic [34:0] rem_reg;
    logic [6:0]  step_reg;
    logic [31:0] sq_r_reg;
    logic [15:0] out_size_reg;
    logic        status_reg, out_valid_reg;
    logic        mul_phase_reg;
    logic [49:0] t1_reg, t2_reg;
    logic signed [31:0] hi_reg;
    logic [15:0] us_reg;

    logic        ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0] rv_data;
    logic [15:0] rs_data;

    logic in_acc;
    assign in_acc    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_size  = out_size_reg;
    assign status    = status_reg;

    assign count_eff = (count_cfg_reg > 4'(bsi_pkg::MAX_ITEMS)) ? CW'(bsi_pkg::MAX_ITEMS)
                                                                  : CW'(count_cfg_reg);
    assign ram_we    = in_acc && (req_type == bsi_pkg::REQ_WRITE)
                       && ({1'b0, entry_index} < 4'(bsi_pkg::MAX_ITEMS));
    assign ram_waddr = AW'(entry_index);
    assign ram_raddr = AW'(idx_reg);

    bsi_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_val (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(entry_value),
        .raddr(ram_raddr), .rdata(rv_data));
    bsi_ram #(.WIDTH(16), .DEPTH(1 << AW)) u_size (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(entry_size),
        .raddr(ram_raddr), .rdata(rs_data));

    logic [34:0] rem_sh;
    logic [63:0] sq_q;
    logic [31:0] sq_try;
    logic [63:0] sq_t2;
    logic [15:0] vint;
    logic signed [32:0] dlo, dhi, dd;
    assign rem_sh = {rem_reg[33:0], num_reg[63]};
    assign sq_q   = quo_reg;
    assign sq_try = sq_r_reg | (32'd1 << step_reg[3:0]);
    assign sq_t2  = sq_try * sq_try;
    // A non-negative Q16.16 value always fits 16 bits after truncation.
    assign vint   = (class_value < 0) ? 16'd0 : class_value[31:16];
    assign dlo = 33'(v_reg) - 33'(lo_reg);
    assign dhi = 33'(hi_reg) - 33'(v_reg);
    assign dd  = 33'(hi_reg) - 33'(lo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= bsi_pkg::MODE_DISCRETE;
            size_type_reg <= 1'b0;
            count_cfg_reg <= 4'd0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            idx_reg       <= '0;
            have_lo_reg   <= 1'b0;
            mul_phase_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    bsi_pkg::CFG_MODE:      mode_reg <= cfg_data[1:0];
                    bsi_pkg::CFG_SIZE_TYPE: size_type_reg <= cfg_data[0];
                    bsi_pkg::CFG_COUNT:     count_cfg_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        v_reg <= class_value;
                        idx_reg <= '0;
                        have_lo_reg <= 1'b0;
                        if (req_type == bsi_pkg::REQ_WRITE)
                        begin
                            out_size_reg <= 16'd0; status_reg <= 1'b0;
                            out_valid_reg <= 1'b1;
                        end
                        else if (mode_reg == bsi_pkg::MODE_VALUE)
                        begin
                            out_size_reg <= vint; status_reg <= 1'b0;
                            out_valid_reg <= 1'b1;
                        end
                        else if (count_eff == '0)
                        begin
                            out_size_reg <= 16'd0; status_reg <= 1'b1;
                            out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            rd_pend_reg <= 1'b1;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    // Read data belongs to entry idx_reg once the pending cycle has passed.
                    status_reg <= 1'b0;
                    if (rd_pend_reg)
                    begin
                        rd_pend_reg <= 1'b0;
                    end
                    else if (mode_reg == bsi_pkg::MODE_CONST)
                    begin
                        out_size_reg <= rs_data; out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (v_reg < $signed(rv_data))
                    begin
                        if (!have_lo_reg || mode_reg == bsi_pkg::MODE_DISCRETE
                            || v_reg <= lo_reg)
                        begin
                            out_size_reg <= have_lo_reg ? ls_reg : rs_data;
                            out_valid_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            hi_reg <= rv_data; us_reg <= rs_data;
                            mul_phase_reg <= 1'b0;
                            state_reg <= S_MUL;
                        end
                    end
                    else if (idx_reg == count_eff - CW'(1))
                    begin
                        out_size_reg <= rs_data; out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        lo_reg <= rv_data; ls_reg <= rs_data; have_lo_reg <= 1'b1;
                        idx_reg <= idx_reg + CW'(1);
                        rd_pend_reg <= 1'b1;
                    end
                end
                S_MUL:
                begin
                    // Phase 0 forms the weights, phase 1 the weighted products.
                    if (!mul_phase_reg)
                    begin
                        if (size_type_reg)
                        begin
                            t1_reg <= 50'(us_reg[15:1] * us_reg[15:1]);
                            t2_reg <= 50'(ls_reg[15:1] * ls_reg[15:1]);
                        end
                        else
                        begin
                            t1_reg <= 50'(us_reg);
                            t2_reg <= 50'(ls_reg);
                        end
                        mul_phase_reg <= 1'b1;
                    end
                    else
                    begin
                        num_reg <= (size_type_reg ?
                            (64'(dlo[31:0]) * t1_reg[29:0] + 64'(dhi[31:0]) * t2_reg[29:0]) << 2 :
                            64'(dlo[31:0]) * t1_reg[15:0] + 64'(dhi[31:0]) * t2_reg[15:0]);
                        den_reg <= 34'(dd[32:0]);
                        rem_reg <= '0;
                        quo_reg <= '0;
                        step_reg <= 7'd0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (rem_sh >= 35'(den_reg))
                    begin
                        rem_reg <= rem_sh - 35'(den_reg);
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                    num_reg <= {num_reg[62:0], 1'b0};
                    if (step_reg == 7'd63)
                    begin
                        if (size_type_reg)
                        begin
                            sq_r_reg <= '0;
                            step_reg <= 7'd15;
                            state_reg <= S_SQRT;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + 7'd1;
                    end
                end
                S_SQRT:
                begin
                    if (sq_t2 <= sq_q)
                    begin
                        sq_r_reg <= sq_try;
                    end
                    step_reg <= step_reg - 7'd1;
                    if (step_reg == 7'd0)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    out_size_reg <= size_type_reg ? sq_r_reg[15:0] : quo_reg[15:0];
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall) else $error("input taken while busy");
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_size) && $stable(status)))
        else $error("result changed while stalled");
    a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && req_type == bsi_pkg::REQ_WRITE) |=> (out_valid && out_size == 16'd0))
        else $error("write result missing");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (out_size == 16'd0)) else $error("error with size");
`endif
endmodule
`default_nettype wire

### bench/bsi_checker.sv
// Watches the block's channels, predicts each result and compares it with the block's output.
`timescale 1ns / 1ps
module bsi_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic               req_type,
    input  wire logic [2:0]         entry_index,
    input  wire logic signed [31:0] entry_value,
    input  wire logic [15:0]        entry_size,
    input  wire logic signed [31:0] class_value,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [15:0]        out_size,
    input  wire logic               status,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [3:0]         cfg_data,
    output int                      errors,
    output int                      pending
);
    localparam int TABLE_DEPTH = bsi_pkg::MAX_ITEMS;

    typedef struct packed {
        logic [15:0] size;
        logic        status;
    } size_result_t;

    size_result_t       size_q[$];
    logic signed [31:0] bp_val [TABLE_DEPTH];
    logic [15:0]        bp_sz [TABLE_DEPTH];
    logic [1:0]         mode_r;
    logic               diam_r;
    logic [3:0]         count_r;

    function automatic logic [15:0] sqrt_floor(logic [63:0] q);
        logic [15:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 15; b >= 0; b--)
        begin
            t = 64'(r | (16'd1 << b));
            if (t * t <= q)
                r = r | (16'd1 << b);
        end
        return r;
    endfunction

    function automatic logic [15:0] blend(longint v, longint lo, longint hi,
                                          logic [15:0] ls, logic [15:0] us);
        logic [63:0] dlo, dhi, span, hl, hu, n, q;
        if (mode_r == bsi_pkg::MODE_DISCRETE || v <= lo)
            return ls;
        if (v >= hi)
            return us;
        dlo  = 64'(v - lo);
        dhi  = 64'(hi - v);
        span = 64'(hi - lo);
        if (!diam_r)
        begin
            q = (dlo * 64'(us) + dhi * 64'(ls)) / span;
            return q[15:0];
        end
        // Diameter sizes: interpolate the area, then convert back to a diameter.
        hl = 64'(ls >> 1);
        hu = 64'(us >> 1);
        n  = dlo * (hu * hu) + dhi * (hl * hl);
        return sqrt_floor((n << 2) / span);
    endfunction

    function automatic size_result_t classify(logic signed [31:0] value);
        size_result_t res;
        int           used;
        longint       v;
        res  = '0;
        v    = longint'(value);
        used = (count_r > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_r);
        if (mode_r == bsi_pkg::MODE_VALUE)
        begin
            if (value < 0)
                res.size = '0;
            else
                res.size = value[31:16];
        end
        else if (used == 0)
        begin
            res.status = 1'b1;
        end
        else if (mode_r == bsi_pkg::MODE_CONST)
        begin
            res.size = bp_sz[0];
        end
        else
        begin
            res.size = bp_sz[used - 1];
            for (int i = 0; i < used; i++)
            begin
                if (value < bp_val[i])
                begin
                    if (i == 0)
                        res.size = bp_sz[0];
                    else
                        res.size = blend(v, longint'(bp_val[i - 1]), longint'(bp_val[i]),
                                         bp_sz[i - 1], bp_sz[i]);
                    break;
                end
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        size_result_t exp_res;
        if (!rst_n)
        begin
            mode_r  = bsi_pkg::MODE_DISCRETE;
            diam_r  = 1'b0;
            count_r = '0;
            errors  = 0;
            pending = 0;
            size_q.delete();
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                bp_val[i] = '0;
                bp_sz[i]  = '0;
            end
        end
        else
        begin
            // Results come out in order, so the oldest prediction is the one to match.
            if (out_valid && !out_stall)
            begin
                if (size_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with nothing expected: size %h status %0d",
                             $time, out_size, status);
                end
                else
                begin
                    exp_res = size_q.pop_front();
                    pending--;
                    if (out_size !== exp_res.size)
                    begin
                        errors++;
                        $display("%0t: out_size expected %h actual %h",
                                 $time, exp_res.size, out_size);
                    end
                    if (status !== exp_res.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_res.status, status);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bsi_pkg::CFG_MODE:      mode_r  = cfg_data[1:0];
                    bsi_pkg::CFG_SIZE_TYPE: diam_r  = cfg_data[0];
                    bsi_pkg::CFG_COUNT:     count_r = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (req_type == bsi_pkg::REQ_WRITE)
                begin
                    bp_val[entry_index] = entry_value;
                    bp_sz[entry_index]  = entry_size;
                    exp_res = '0;
                end
                else
                begin
                    exp_res = classify(class_value);
                end
                size_q = {size_q, exp_res};
                pending++;
            end
        end
    end
endmodule

### bench/tb.sv
// Testbench top: drives table writes, classify requests and register writes; gives the verdict.
`timescale 1ns / 1ps
module tb;
    localparam int ITEM_TARGET = 1850;
    localparam int IDLE_LIMIT  = 3000;
    localparam int DRAIN_WAIT  = 200;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               req_type;
    logic [2:0]         entry_index;
    logic signed [31:0] entry_value;
    logic [15:0]        entry_size;
    logic signed [31:0] class_value;
    logic               out_valid;
    logic               out_stall;
    logic [15:0]        out_size;
    logic               status;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [3:0]         cfg_data;
    int                 errors;
    int                 pending;
    int                 items_sent;
    int                 idle_cycles;
    bit                 quiet;
    logic signed [31:0] tbl_val [8];

    breakpoint_size_interpolator_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .entry_index(entry_index), .entry_value(entry_value),
        .entry_size(entry_size), .class_value(class_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_size(out_size), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    bsi_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .entry_index(entry_index), .entry_value(entry_value),
        .entry_size(entry_size), .class_value(class_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_size(out_size), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Receiver back-pressure: stall runs of random length between short open windows.
    initial
    begin
        int len;
        out_stall = 1'b0;
        forever
        begin
            len = gap_len();
            repeat (len) @(negedge clk) out_stall = 1'b1;
            repeat ($urandom_range(1, 4)) @(negedge clk) out_stall = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send(logic rt, logic [2:0] idx, logic signed [31:0] ev,
                        logic [15:0] es, logic signed [31:0] cv);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid = 1'b0;
            repeat (g) @(negedge clk);
        end
        req_type    = rt;
        entry_index = idx;
        entry_value = ev;
        entry_size  = es;
        class_value = cv;
        in_valid    = 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        if (rt == bsi_pkg::REQ_WRITE)
            tbl_val[idx] = ev;
        items_sent++;
    endtask

    task automatic write_entry(logic [2:0] idx, logic signed [31:0] ev, logic [15:0] es);
        send(bsi_pkg::REQ_WRITE, idx, ev, es, $urandom());
    endtask

    task automatic classify(logic signed [31:0] cv);
        send(bsi_pkg::REQ_CLASSIFY, 3'($urandom()), $urandom(), 16'($urandom()), cv);
    endtask

    // Registers change only with the block idle: every item yields a result,
    // so an empty prediction store plus a latency margin means nothing is in flight.
    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic setup(logic [1:0] m, logic st, logic [3:0] cnt);
        wait_idle();
        write_reg(bsi_pkg::CFG_MODE, 4'(m));
        write_reg(bsi_pkg::CFG_SIZE_TYPE, 4'(st));
        write_reg(bsi_pkg::CFG_COUNT, cnt);
    endtask

    task automatic load_table(bit sorted);
        logic signed [31:0] vals [8];
        logic signed [31:0] tmp;
        int                 scale;
        scale = $urandom_range(0, 3);
        for (int i = 0; i < 8; i++)
        begin
            case (scale)
                0: vals[i] = $urandom();
                1: vals[i] = $signed($urandom_range(0, 2 ** 21)) - 32'sd1048576;
                2: vals[i] = $signed($urandom_range(0, 64)) - 32'sd32;
                default: vals[i] = (i > 0 && $urandom_range(0, 2) == 0) ? vals[i - 1]
                                   : $signed($urandom_range(0, 2 ** 24)) - 32'sd8388608;
            endcase
        end
        if (sorted)
        begin
            for (int i = 0; i < 7; i++)
                for (int j = 0; j < 7 - i; j++)
                    if (vals[j] > vals[j + 1])
                    begin
                        tmp         = vals[j];
                        vals[j]     = vals[j + 1];
                        vals[j + 1] = tmp;
                    end
        end
        for (int i = 0; i < 8; i++)
            write_entry(i[2:0], vals[i],
                        ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 20)) : 16'($urandom()));
    endtask

    function automatic logic signed [31:0] pick_value();
        int     k;
        int     r;
        longint lo;
        longint hi;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 7);
        if (r < 35)
            return tbl_val[k] + ($signed($urandom_range(0, 6)) - 3);
        if (r < 75 && k < 7)
        begin
            lo = longint'(tbl_val[k]);
            hi = longint'(tbl_val[k + 1]);
            if (hi > lo)
                return 32'(lo + longint'({$urandom(), $urandom()} % 64'(hi - lo)));
            return tbl_val[k];
        end
        if (r < 85)
            return $signed($urandom_range(0, 2 ** 24));
        return $urandom();
    endfunction

    initial
    begin
        int n;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        req_type    = bsi_pkg::REQ_WRITE;
        entry_index = '0;
        entry_value = '0;
        entry_size  = '0;
        class_value = '0;
        cfg_valid   = 1'b0;
        cfg_index   = bsi_pkg::CFG_MODE;
        cfg_data    = '0;
        items_sent  = 0;
        idle_cycles = 0;
        quiet       = 1'b0;
        for (int i = 0; i < 8; i++)
            tbl_val[i] = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed part. An empty table after reset reports the error status.
        classify(32'sd0);
        write_entry(3'd0, 32'sh8000_0000, 16'd0);
        write_entry(3'd1, -32'sd65536, 16'hffff);
        write_entry(3'd2, 32'sd0, 16'd100);
        write_entry(3'd3, 32'sd655360, 16'd2);
        write_entry(3'd4, 32'sd6553600, 16'hfffe);
        write_entry(3'd5, 32'sh7fff_0000, 16'd1);
        write_entry(3'd6, 32'sh7fff_fffe, 16'd7);
        write_entry(3'd7, 32'sh7fff_ffff, 16'hffff);
        setup(bsi_pkg::MODE_LINEAR, 1'b0, 4'd8);
        classify(32'sh8000_0000);
        classify(32'sh7fff_ffff);
        classify(32'sd0);
        classify(32'sd327680);
        classify(-32'sd1);
        setup(bsi_pkg::MODE_LINEAR, 1'b1, 4'd8);
        classify(32'sd327680);
        classify(32'sd3000000);
        setup(bsi_pkg::MODE_VALUE, 1'b0, 4'd0);
        classify(-32'sd1);
        classify(32'sh7fff_ffff);
        classify(32'sd98304);
        setup(bsi_pkg::MODE_CONST, 1'b1, 4'd15);
        classify(32'sd12345);
        setup(bsi_pkg::MODE_DISCRETE, 1'b0, 4'd15);
        classify(32'sd327680);
        classify(32'sh7fff_ffff);
        setup(bsi_pkg::MODE_CONST, 1'b0, 4'd0);
        classify(32'sd5);

        // Random phases: new settings, often a fresh table, then a burst of requests.
        while (items_sent < ITEM_TARGET)
        begin
            quiet = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 5))
                0: setup(2'($urandom()), 1'($urandom()), 4'd0);
                1: setup(2'($urandom()), 1'($urandom()), 4'd15);
                2: setup(bsi_pkg::MODE_LINEAR, 1'($urandom()), 4'd8);
                default: setup(2'($urandom()), 1'($urandom()), 4'($urandom_range(0, 15)));
            endcase
            if ($urandom_range(0, 1) == 0)
                load_table($urandom_range(0, 4) != 0);
            n = $urandom_range(20, 60);
            repeat (n)
            begin
                if ($urandom_range(0, 9) == 0)
                    write_entry(3'($urandom()), pick_value(), 16'($urandom()));
                else
                    classify(pick_value());
            end
        end

        quiet    = 1'b1;
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

### filelist.f
sv/bsi_pkg.sv
sv/bsi_ram.sv
sv/breakpoint_size_interpolator_core.sv
bench/bsi_checker.sv
bench/tb.sv
